/* hw/rtl/q4dq_pkg.sv */
// ----------------------------------------------------------------------------
// q4dq_pkg: shared types and functions of the Q4_0 block dequantizer
// Holds the payload structs of both channels and the scalar FP helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package q4dq_pkg;
  localparam int unsigned BlockElements = 32;
  localparam int unsigned ElemsPerResult = 8;
  localparam int unsigned Groups = BlockElements / ElemsPerResult;
  localparam int unsigned GroupW = $clog2(Groups);

  typedef struct packed {
    logic [15:0] scale_half;
    logic [63:0] packed_low;
    logic [63:0] packed_high;
    logic        final_block;
  } in_item_t;

  typedef struct packed {
    logic [31:0] elem_0_bits;
    logic [31:0] elem_1_bits;
    logic [31:0] elem_2_bits;
    logic [31:0] elem_3_bits;
    logic [31:0] elem_4_bits;
    logic [31:0] elem_5_bits;
    logic [31:0] elem_6_bits;
    logic [31:0] elem_7_bits;
    logic [1:0]  group_index;
    logic        block_done;
    logic        row_end;
  } out_item_t;

  // Half to single conversion; subnormals are normalized.
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [31:0] r;
    logic [9:0]  man;
    logic [4:0]  ex;
    logic [3:0]  lz;
    logic [10:0] sh;
    begin
      ex  = h[14:10];
      man = h[9:0];
      lz  = 4'd0;
      for (int i = 9; i >= 0; i--) begin
        if (man[i] && lz == 4'd0) lz = 4'(10 - i);
      end
      sh = {1'b0, man} << lz;
      if (ex == 5'd0) begin
        if (man == 10'd0) r = {h[15], 31'd0};
        else r = {h[15], 8'(8'd113 - {4'd0, lz}), sh[9:0], 13'd0};
      end else if (ex == 5'h1F) begin
        r = {h[15], 8'hFF, man, 13'd0};
      end else begin
        r = {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
      end
      half_to_single = r;
    end
  endfunction

  // Exact product of single s (from a half) and the signed value code-8.
  function automatic logic [31:0] scale_code(input logic [31:0] s, input logic [3:0] code);
    logic        neg;
    logic        sg;
    logic [3:0]  mag;
    logic [7:0]  ex;
    logic [26:0] p;
    logic [31:0] r;
    begin
      neg = ~code[3];
      mag = neg ? 4'(4'd8 - code) : {1'b0, code[2:0]};
      sg  = s[31] ^ neg;
      ex  = s[30:23];
      p   = {3'd0, 1'b1, s[22:0]} * {23'd0, mag};
      if (ex == 8'hFF) begin
        if (s[22:0] != 23'd0) r = s | 32'h0040_0000;
        else if (mag == 4'd0) r = 32'hFFC0_0000;
        else r = {sg, 8'hFF, 23'd0};
      end else if (ex == 8'd0 || mag == 4'd0) begin
        r = {sg, 31'd0};
      end else if (p[26]) begin
        r = {sg, 8'(ex + 8'd3), p[25:3]};
      end else if (p[25]) begin
        r = {sg, 8'(ex + 8'd2), p[24:2]};
      end else if (p[24]) begin
        r = {sg, 8'(ex + 8'd1), p[23:1]};
      end else begin
        r = {sg, ex, p[22:0]};
      end
      scale_code = r;
    end
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/q4dq_stream_if.sv */
// ----------------------------------------------------------------------------
// q4dq_stream_if: valid/ready channel carrying a payload
// One transfer happens on each edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none
interface q4dq_in_if;
  logic valid;
  logic ready;
  q4dq_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface q4dq_out_if;
  logic valid;
  logic ready;
  q4dq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/q4dq_lanes.sv */
// ----------------------------------------------------------------------------
// q4dq_lanes: eight element lanes for one group
// Scales eight codes by the single-precision scale, combinationally.
// ----------------------------------------------------------------------------
`default_nettype none
module q4dq_lanes (
  input  wire logic [31:0] scale_i,
  input  wire logic [31:0] codes_i,
  output logic [8*32-1:0]  elems_o
);
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      elems_o[32*i +: 32] = q4dq_pkg::scale_code(scale_i, codes_i[4*i +: 4]);
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/q4_block_dequantizer.sv */
// ----------------------------------------------------------------------------
// q4_block_dequantizer: Q4_0 block to FP32 dequantizer
// Turns one block (half scale, 32 nibbles) into four results of eight floats.
// ----------------------------------------------------------------------------
// Usage: blocks arrive on in_if; each accepted block yields four transfers on
// out_if, groups 0..3 in order, block_done on group 3 and row_end on group 3
// of a block flagged final_block.
// Pipeline: stage 1 registers the block and converts the scale to single;
// stage 2 holds the current block while a group counter walks it, selecting
// eight codes per cycle unless out_if stalls; stage 3 registers the eight
// scaled products as the output register, giving eight floats per cycle
// while out_if is not stalled. The input is taken whenever stage 1 is empty
// or the sequencer is free or moving on from its last group, so blocks
// follow each other without a gap.
// A stall on out_if holds the output and every full stage behind it in
// place; empty stages still fill. Nothing is lost or repeated.
// Reset clears all valid bits and the group counter; payload is not reset.
// ----------------------------------------------------------------------------
`default_nettype none
module q4_block_dequantizer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  q4dq_in_if.sink   in_if,
  q4dq_out_if.source out_if
);
  logic        s3_adv;
  logic        s3_vld_q;
  logic        s2_vld_q, s2_adv, s2_last;
  logic [1:0]  grp_q;
  logic        s1_vld_q, s1_adv;
  logic [31:0] s1_scale_q, s2_scale_q;
  logic [127:0] s1_pk_q, s2_pk_q;
  logic        s1_fin_q, s2_fin_q;
  logic [31:0] codes;
  logic [8*32-1:0] elems;
  q4dq_pkg::out_item_t out_q;

  assign s3_adv  = ~s3_vld_q | out_if.ready;
  assign s2_last = grp_q == 2'd3;
  assign s2_adv  = ~s2_vld_q | (s3_adv & s2_last);
  assign s1_adv  = ~s1_vld_q | s2_adv;
  assign in_if.ready = s1_adv;

  // Stage 1: register the block and convert the scale.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_adv) begin
      s1_vld_q <= in_if.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (s1_adv && in_if.valid) begin
      s1_scale_q <= q4dq_pkg::half_to_single(in_if.data.scale_half);
      s1_pk_q    <= {in_if.data.packed_high, in_if.data.packed_low};
      s1_fin_q   <= in_if.data.final_block;
    end
  end

  // Stage 2: group sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      grp_q    <= 2'd0;
    end else if (s2_adv) begin
      s2_vld_q <= s1_vld_q;
      grp_q    <= 2'd0;
    end else if (s3_adv) begin
      grp_q <= grp_q + 2'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_vld_q) begin
      s2_scale_q <= s1_scale_q;
      s2_pk_q    <= s1_pk_q;
      s2_fin_q   <= s1_fin_q;
    end
  end

  // Groups 0,1 take low nibbles of bytes 0..15; groups 2,3 the high nibbles.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      codes[4*i +: 4] = s2_pk_q[{grp_q[0], 3'(i), grp_q[1], 2'b00} +: 4];
    end
  end

  q4dq_lanes u_lanes (
    .scale_i (s2_scale_q),
    .codes_i (codes),
    .elems_o (elems)
  );

  // Stage 3: output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (s3_adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (s3_adv && s2_vld_q) begin
      out_q.elem_0_bits <= elems[31:0];
      out_q.elem_1_bits <= elems[63:32];
      out_q.elem_2_bits <= elems[95:64];
      out_q.elem_3_bits <= elems[127:96];
      out_q.elem_4_bits <= elems[159:128];
      out_q.elem_5_bits <= elems[191:160];
      out_q.elem_6_bits <= elems[223:192];
      out_q.elem_7_bits <= elems[255:224];
      out_q.group_index <= grp_q;
      out_q.block_done  <= s2_last;
      out_q.row_end     <= s2_last & s2_fin_q;
    end
  end

  assign out_if.valid = s3_vld_q;
  assign out_if.data  = out_q;
endmodule
`default_nettype wire
